FILE: rtl/mps_pkg.sv
// Shared types, constants and helpers for the MQTT packet serializer.
// Used by the front end, the command queue, the byte sequencer and the top level.
// No dependencies.
package mps_pkg;

  // Field widths of the streaming channels.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SLEN_W      = 16;
  localparam int unsigned PLEN_W      = 28;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 3;

  // Remaining length is computed one bit wider than the largest legal value.
  localparam int unsigned REM_W = PLEN_W + 1;

  // Remaining-length digits carry seven bits each.
  localparam int unsigned DIGIT_W = 7;

  // Command queue geometry.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned CMD_CNT_W = 3;

  // Input action codes.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_BODY  = 1'b1;

  // Packet kinds.
  localparam logic [KIND_W-1:0] KIND_CONNECT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUBSCRIBE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PUBLISH   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNEXPECTED = 2'd2;

  // Fixed header type bytes.
  localparam logic [BYTE_W-1:0] TYPE_CONNECT   = 8'h10;
  localparam logic [BYTE_W-1:0] TYPE_SUBSCRIBE = 8'h82;
  localparam logic [BYTE_W-1:0] TYPE_PUBLISH   = 8'h32;

  // CONNECT variable header bytes.
  localparam logic [BYTE_W-1:0] PROTO_LEVEL   = 8'h04;
  localparam logic [BYTE_W-1:0] CONNECT_FLAGS = 8'h02;
  localparam logic [BYTE_W-1:0] NAME_LEN_LO   = 8'h04;
  localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

  // Remaining length added to the string length for each kind.
  localparam logic [REM_W-1:0] REM_BASE_CONNECT   = 29'd12;
  localparam logic [REM_W-1:0] REM_BASE_SUBSCRIBE = 29'd5;
  localparam logic [REM_W-1:0] REM_BASE_PUBLISH   = 29'd4;

  // Positions in the fixed variable-header run. The last two carry the 16-bit word.
  localparam int unsigned FIX_IDX_W = 4;
  localparam logic [FIX_IDX_W-1:0] FIX_FIRST_IDX = 4'd0;
  localparam logic [FIX_IDX_W-1:0] FIX_WORD_HI   = 4'd8;
  localparam logic [FIX_IDX_W-1:0] FIX_WORD_LO   = 4'd9;

  // Operations passed from the front end to the byte sequencer.
  typedef enum logic [1:0] {
    OP_HEADER,
    OP_STRING,
    OP_PAYLOAD,
    OP_ERROR
  } op_t;

  // One queued command: everything the sequencer needs to emit its bytes.
  typedef struct packed {
    op_t                 op;
    logic [KIND_W-1:0]   kind;
    logic [PLEN_W-1:0]   rem;       // remaining length for a header
    logic [WORD_W-1:0]   word;      // keepalive or packet id
    logic [SLEN_W-1:0]   slen;      // string length prefix
    logic [BYTE_W-1:0]   data;      // body byte
    logic                tail;      // the string ends with this command
    logic                pay_zero;  // no payload follows the string
    logic [STATUS_W-1:0] status;    // error status
    logic                pend;      // byte ends the packet (payload and error)
  } cmd_t;

  // Fixed CONNECT bytes: protocol name with its length, level and flags.
  function automatic logic [BYTE_W-1:0] connect_byte(input logic [FIX_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0:    b = ZERO_BYTE;
      4'd1:    b = NAME_LEN_LO;
      4'd2:    b = 8'h4D;  // 'M'
      4'd3:    b = 8'h51;  // 'Q'
      4'd4:    b = 8'h54;  // 'T'
      4'd5:    b = 8'h54;  // 'T'
      4'd6:    b = PROTO_LEVEL;
      4'd7:    b = CONNECT_FLAGS;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/mqtt_packet_serializer.sv
// Top level of the MQTT 3.1.1 packet serializer (CONNECT, SUBSCRIBE, PUBLISH QoS 1).
// Instantiates the front end, the command queue and the byte sequencer; uses mps_pkg.
//
// Usage: the input channel carries one request per transfer. in_tuser says whether
// it begins a packet (0) or carries one body byte (1). A begin request gives the
// kind, string length, payload length and the keepalive or packet id; body
// requests then bring the client id or topic bytes and any publish payload.
// The output channel carries one wire byte per transfer; out_tlast marks the last
// byte of a packet, out_tuser carries the last-result flag of the request and a
// status (too long, unexpected byte), with a zero byte on every error result.
// Throughput: one request can be accepted every cycle while the four-entry command
// queue has room; the sequencer emits one byte per cycle while out_tready is high.
// A body request yields one byte, two when it closes a subscribe topic and three
// when it closes a publish topic; a begin yields up to 16 bytes for a CONNECT.
// A request's first byte passes through the command queue and the output register.
// When the receiver stalls, the output register holds its byte, the sequencer
// waits, and the queue fills until in_tready drops. Reset clears the packet
// phase, the queue and the output register; no packet is in progress.
module mqtt_packet_serializer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // kind[1:0], string_length[17:2], payload_length[45:18], packet_word[61:46],
  // data_byte[69:62], zero fill[71:70]
  input  logic [mps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_byte[7:0]
  output logic [mps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // run_last[0], status[2:1]
  output logic [mps_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  logic          cmd_full;
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_valid;
  mps_pkg::cmd_t cmd_in;
  mps_pkg::cmd_t cmd_head;

  // Request classification and packet state.
  mps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  // Decoupling queue.
  mps_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .head      (cmd_head)
  );

  // Byte generation and output register.
  mps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/mps_front.sv
// Front end of the MQTT packet serializer: accepts input requests, tracks the
// packet phase and turns each request into one command for the byte sequencer.
// Depends on mps_pkg.
module mps_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mps_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             cmd_full,
  output logic                             cmd_push,
  output mps_pkg::cmd_t                    cmd_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STRING,
    PH_PAYLOAD
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [mps_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [mps_pkg::SLEN_W-1:0]     string_left_r, string_left_nxt;
  logic [mps_pkg::PLEN_W-1:0]     payload_left_r, payload_left_nxt;
  logic [mps_pkg::WORD_W-1:0]     word_r, word_nxt;

  logic                           accept;
  logic [mps_pkg::KIND_W-1:0]     f_kind;
  logic [mps_pkg::SLEN_W-1:0]     f_slen;
  logic [mps_pkg::PLEN_W-1:0]     f_plen;
  logic [mps_pkg::WORD_W-1:0]     f_word;
  logic [mps_pkg::BYTE_W-1:0]     f_data;
  logic [mps_pkg::REM_W-1:0]      rem_base;
  logic [mps_pkg::REM_W-1:0]      rem_sum;
  logic [mps_pkg::SLEN_W-1:0]     string_dec;
  logic [mps_pkg::PLEN_W-1:0]     payload_dec;

  // Unpack the request fields.
  assign f_kind = in_tdata[1:0];
  assign f_slen = in_tdata[17:2];
  assign f_plen = in_tdata[45:18];
  assign f_word = in_tdata[61:46];
  assign f_data = in_tdata[69:62];

  // A request is taken whenever the command queue has room.
  assign in_tready = !cmd_full;
  assign accept    = in_tvalid && in_tready;
  assign cmd_push  = accept;

  // Remaining length of a new packet; the top bit flags an oversize packet.
  always_comb begin
    unique case (f_kind)
      mps_pkg::KIND_CONNECT:   rem_base = mps_pkg::REM_BASE_CONNECT;
      mps_pkg::KIND_SUBSCRIBE: rem_base = mps_pkg::REM_BASE_SUBSCRIBE;
      default:                 rem_base = mps_pkg::REM_BASE_PUBLISH;
    endcase
  end

  assign rem_sum = rem_base + mps_pkg::REM_W'(f_slen) +
                   ((f_kind == mps_pkg::KIND_PUBLISH) ? mps_pkg::REM_W'(f_plen)
                                                      : mps_pkg::REM_W'(0));

  assign string_dec  = string_left_r - 1'b1;
  assign payload_dec = payload_left_r - 1'b1;

  // Phase tracking and command building.
  always_comb begin
    phase_nxt        = phase_r;
    kind_nxt         = kind_r;
    string_left_nxt  = string_left_r;
    payload_left_nxt = payload_left_r;
    word_nxt         = word_r;
    cmd_data         = '0;
    cmd_data.op      = mps_pkg::OP_ERROR;
    cmd_data.status  = mps_pkg::STATUS_UNEXPECTED;

    if (accept) begin
      if (in_tuser == mps_pkg::ACT_BEGIN) begin
        if (f_kind == mps_pkg::KIND_UNKNOWN) begin
          phase_nxt       = PH_IDLE;
          cmd_data.op     = mps_pkg::OP_ERROR;
          cmd_data.status = mps_pkg::STATUS_UNEXPECTED;
          cmd_data.pend   = 1'b1;
        end else if (rem_sum[mps_pkg::REM_W-1]) begin
          phase_nxt       = PH_IDLE;
          cmd_data.op     = mps_pkg::OP_ERROR;
          cmd_data.status = mps_pkg::STATUS_TOO_LONG;
          cmd_data.pend   = 1'b1;
        end else begin
          kind_nxt         = f_kind;
          string_left_nxt  = f_slen;
          payload_left_nxt = (f_kind == mps_pkg::KIND_PUBLISH) ? f_plen : '0;
          word_nxt         = f_word;
          cmd_data.op      = mps_pkg::OP_HEADER;
          cmd_data.status  = mps_pkg::STATUS_OK;
          cmd_data.kind    = f_kind;
          cmd_data.rem     = rem_sum[mps_pkg::PLEN_W-1:0];
          cmd_data.word    = f_word;
          cmd_data.slen    = f_slen;
          cmd_data.tail    = (f_slen == '0);
          cmd_data.pay_zero = (payload_left_nxt == '0);
          if (f_slen != '0) begin
            phase_nxt = PH_STRING;
          end else if (payload_left_nxt != '0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end else begin
        unique case (phase_r)
          PH_STRING: begin
            string_left_nxt   = string_dec;
            cmd_data.op       = mps_pkg::OP_STRING;
            cmd_data.status   = mps_pkg::STATUS_OK;
            cmd_data.kind     = kind_r;
            cmd_data.word     = word_r;
            cmd_data.data     = f_data;
            cmd_data.tail     = (string_dec == '0);
            cmd_data.pay_zero = (payload_left_r == '0);
            if (string_dec == '0) begin
              phase_nxt = (kind_r == mps_pkg::KIND_PUBLISH && payload_left_r != '0)
                          ? PH_PAYLOAD : PH_IDLE;
            end
          end
          PH_PAYLOAD: begin
            payload_left_nxt = payload_dec;
            cmd_data.op      = mps_pkg::OP_PAYLOAD;
            cmd_data.status  = mps_pkg::STATUS_OK;
            cmd_data.data    = f_data;
            cmd_data.pend    = (payload_dec == '0);
            if (payload_dec == '0) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            // Body byte outside a packet.
            cmd_data.op     = mps_pkg::OP_ERROR;
            cmd_data.status = mps_pkg::STATUS_UNEXPECTED;
            cmd_data.pend   = 1'b0;
          end
        endcase
      end
    end
  end

  // Packet state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      kind_r         <= '0;
      string_left_r  <= '0;
      payload_left_r <= '0;
      word_r         <= '0;
    end else begin
      phase_r        <= phase_nxt;
      kind_r         <= kind_nxt;
      string_left_r  <= string_left_nxt;
      payload_left_r <= payload_left_nxt;
      word_r         <= word_nxt;
    end
  end

endmodule

FILE: rtl/mps_cmd_fifo.sv
// Short command queue between the front end and the byte sequencer of the
// MQTT packet serializer. Depends on mps_pkg for the command type and depth.
module mps_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mps_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output mps_pkg::cmd_t head
);

  mps_pkg::cmd_t                  mem_r [mps_pkg::CMD_DEPTH];
  logic [mps_pkg::CMD_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [mps_pkg::CMD_CNT_W-1:0]  count_r;

  assign full  = (count_r == mps_pkg::CMD_CNT_W'(mps_pkg::CMD_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Storage is written only when a request is pushed.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/mps_back.sv
// Byte sequencer of the MQTT packet serializer: expands the command at the head
// of the queue into wire bytes, one per cycle unless the output is stalled.
// Depends on mps_pkg.
module mps_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  mps_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic [mps_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  typedef enum logic [2:0] {
    B_FIRST,
    B_DIGIT,
    B_FIX,
    B_SLHI,
    B_SLLO,
    B_TAIL0,
    B_TAIL1
  } bst_t;

  bst_t                             st_r, st_nxt;
  logic [mps_pkg::PLEN_W-1:0]       rem_r, rem_nxt;
  logic [mps_pkg::FIX_IDX_W-1:0]    idx_r, idx_nxt;
  logic                             out_valid_r;
  logic [mps_pkg::BYTE_W-1:0]       out_byte_r, byte_v;
  logic                             run_last_r, run_last_v;
  logic                             end_r, end_v;
  logic [mps_pkg::STATUS_W-1:0]     status_r, status_v;

  logic                             advance;
  logic                             fire;
  logic                             more;

  // The output register takes a new byte when empty or when the receiver takes it.
  assign advance = !out_valid_r || out_tready;
  assign fire    = advance && cmd_valid;
  assign more    = (rem_r[mps_pkg::PLEN_W-1:mps_pkg::DIGIT_W] != '0);
  assign cmd_pop = fire && run_last_v;

  // Byte selection and next step for the current command.
  always_comb begin
    st_nxt     = st_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    byte_v     = mps_pkg::ZERO_BYTE;
    run_last_v = 1'b0;
    end_v      = 1'b0;
    status_v   = mps_pkg::STATUS_OK;

    unique case (st_r)
      B_FIRST: begin
        unique case (cmd.op)
          mps_pkg::OP_ERROR: begin
            status_v   = cmd.status;
            end_v      = cmd.pend;
            run_last_v = 1'b1;
          end
          mps_pkg::OP_PAYLOAD: begin
            byte_v     = cmd.data;
            end_v      = cmd.pend;
            run_last_v = 1'b1;
          end
          mps_pkg::OP_STRING: begin
            byte_v = cmd.data;
            if (!cmd.tail) begin
              run_last_v = 1'b1;
            end else if (cmd.kind == mps_pkg::KIND_CONNECT) begin
              end_v      = 1'b1;
              run_last_v = 1'b1;
            end else begin
              st_nxt = B_TAIL0;
            end
          end
          default: begin
            // Header: type byte, then the length digits.
            unique case (cmd.kind)
              mps_pkg::KIND_CONNECT:   byte_v = mps_pkg::TYPE_CONNECT;
              mps_pkg::KIND_SUBSCRIBE: byte_v = mps_pkg::TYPE_SUBSCRIBE;
              default:                 byte_v = mps_pkg::TYPE_PUBLISH;
            endcase
            rem_nxt = cmd.rem;
            st_nxt  = B_DIGIT;
          end
        endcase
      end
      B_DIGIT: begin
        // Seven bits a digit, least significant first, bit 7 marks more digits.
        byte_v  = {more, rem_r[mps_pkg::DIGIT_W-1:0]};
        rem_nxt = rem_r >> mps_pkg::DIGIT_W;
        if (!more) begin
          if (cmd.kind == mps_pkg::KIND_CONNECT) begin
            st_nxt  = B_FIX;
            idx_nxt = mps_pkg::FIX_FIRST_IDX;
          end else if (cmd.kind == mps_pkg::KIND_SUBSCRIBE) begin
            st_nxt  = B_FIX;
            idx_nxt = mps_pkg::FIX_WORD_HI;
          end else begin
            st_nxt = B_SLHI;
          end
        end
      end
      B_FIX: begin
        if (idx_r == mps_pkg::FIX_WORD_HI) begin
          byte_v = cmd.word[15:8];
        end else if (idx_r == mps_pkg::FIX_WORD_LO) begin
          byte_v = cmd.word[7:0];
        end else begin
          byte_v = mps_pkg::connect_byte(idx_r);
        end
        if (idx_r == mps_pkg::FIX_WORD_LO) begin
          st_nxt = B_SLHI;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      B_SLHI: begin
        byte_v = cmd.slen[15:8];
        st_nxt = B_SLLO;
      end
      B_SLLO: begin
        byte_v = cmd.slen[7:0];
        if (!cmd.tail) begin
          run_last_v = 1'b1;
        end else if (cmd.kind == mps_pkg::KIND_CONNECT) begin
          // An empty client id ends the packet on the length prefix.
          end_v      = 1'b1;
          run_last_v = 1'b1;
        end else begin
          st_nxt = B_TAIL0;
        end
      end
      B_TAIL0: begin
        if (cmd.kind == mps_pkg::KIND_SUBSCRIBE) begin
          // Requested QoS byte closes a subscribe.
          byte_v     = mps_pkg::ZERO_BYTE;
          end_v      = 1'b1;
          run_last_v = 1'b1;
        end else begin
          byte_v = cmd.word[15:8];
          st_nxt = B_TAIL1;
        end
      end
      B_TAIL1: begin
        byte_v     = cmd.word[7:0];
        end_v      = cmd.pay_zero;
        run_last_v = 1'b1;
      end
      default: begin
        run_last_v = 1'b1;
      end
    endcase

    if (run_last_v) begin
      st_nxt = B_FIRST;
    end
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rem_r      <= rem_nxt;
      idx_r      <= idx_nxt;
      out_byte_r <= byte_v;
      run_last_r <= run_last_v;
      end_r      <= end_v;
      status_r   <= status_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = end_r;
  assign out_tuser  = {status_r, run_last_r};

  // A command being expanded stays at the head of the queue.
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != B_FIRST) |-> cmd_valid)
    else $error("sequencer mid-command with an empty queue");

  // Length digits only belong to a header command.
  a_digit_header: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIGIT) |-> (cmd.op == mps_pkg::OP_HEADER))
    else $error("length digit for a non-header command");

  // The packet id after the topic belongs to a publish.
  a_tail1_publish: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_TAIL1) |-> (cmd.kind == mps_pkg::KIND_PUBLISH))
    else $error("packet id tail outside a publish");

  // The fixed-header index never runs past the word bytes.
  a_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FIX) |-> (idx_r <= mps_pkg::FIX_WORD_LO))
    else $error("fixed header index out of range");

endmodule

FILE: tb/sv/mqtt_packet_serializer_tb.sv
// Self-checking testbench for mqtt_packet_serializer: a directed table, then random packets.
// Expected wire bytes come from a predictor kept inside this file; uses mps_pkg and the RTL.
module mqtt_packet_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mps_pkg::*;

  localparam int unsigned    QUIET_LIMIT  = 2000;
  localparam int unsigned    RANDOM_ITEMS = 450;
  localparam int unsigned    TAIL_CYCLES  = 40;
  localparam int unsigned    PRINT_CAP    = 40;
  localparam logic [29:0]    REM_LIMIT    = 30'd268435455;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STRING,
    PH_PAYLOAD
  } pkt_phase_t;

  // One request on the input channel, plus an optional typed-in single result.
  typedef struct {
    logic                action;
    logic [KIND_W-1:0]   kind;
    logic [SLEN_W-1:0]   slen;
    logic [PLEN_W-1:0]   plen;
    logic [WORD_W-1:0]   word;
    logic [BYTE_W-1:0]   data;
    bit                  typed;
    logic                t_end;
    logic [STATUS_W-1:0] t_status;
  } request_t;

  // One byte on the output channel with its flags.
  typedef struct {
    logic [BYTE_W-1:0]   b;
    logic                run_last;
    logic                pend;
    logic [STATUS_W-1:0] status;
  } wire_byte_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Predictor state.
  pkt_phase_t             ser_phase = PH_IDLE;
  logic [KIND_W-1:0]      ser_kind  = KIND_CONNECT;
  logic [SLEN_W-1:0]      str_left  = '0;
  logic [PLEN_W-1:0]      pay_left  = '0;
  logic [WORD_W-1:0]      id_word   = '0;

  wire_byte_t             burst_q[$];
  wire_byte_t             wire_byte_q[$];

  int                     n_errors   = 0;
  int                     n_requests = 0;
  int                     n_begins   = 0;
  int                     n_results  = 0;
  int                     n_packets  = 0;
  int                     n_faults   = 0;
  int                     quiet      = 0;
  int                     cyc        = 0;
  int                     rx_wait    = 0;
  bit                     calm       = 1'b0;

  mqtt_packet_serializer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Print one mismatch line, up to a cap, and count every one.
  task automatic report_mismatch(string what, int want, int got);
    if (n_errors < PRINT_CAP) begin
      $display("%0t ns: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
    n_errors++;
  endtask

  function automatic void put_byte(logic [BYTE_W-1:0] b, logic pend, logic [STATUS_W-1:0] st);
    wire_byte_t w;
    w.b        = b;
    w.run_last = 1'b0;
    w.pend     = pend;
    w.status   = st;
    burst_q.push_back(w);
  endfunction

  // Close the client id or topic: flag its last byte or queue the bytes that follow it.
  function automatic void close_string();
    wire_byte_t w;
    if (ser_kind == KIND_CONNECT) begin
      // The client id closes the packet: flag the byte just queued.
      if (burst_q.size() > 0) begin
        w = burst_q.pop_back();
        w.pend = 1'b1;
        burst_q.push_back(w);
      end
      ser_phase = PH_IDLE;
    end else if (ser_kind == KIND_SUBSCRIBE) begin
      put_byte(ZERO_BYTE, 1'b1, STATUS_OK);
      ser_phase = PH_IDLE;
    end else begin
      put_byte(id_word[15:8], 1'b0, STATUS_OK);
      put_byte(id_word[7:0], pay_left == '0, STATUS_OK);
      ser_phase = (pay_left == '0) ? PH_IDLE : PH_PAYLOAD;
    end
  endfunction

  // Work out the wire bytes one request produces and advance the packet state.
  function automatic void serialize_request(request_t r);
    logic [29:0]       rem;
    logic [BYTE_W-1:0] digit;
    logic [BYTE_W-1:0] type_byte;
    wire_byte_t        w;
    burst_q.delete();
    if (r.action == ACT_BEGIN) begin
      if (r.kind == KIND_UNKNOWN) begin
        ser_phase = PH_IDLE;
        put_byte(ZERO_BYTE, 1'b1, STATUS_UNEXPECTED);
      end else begin
        case (r.kind)
          KIND_CONNECT: begin
            rem       = 30'd12 + 30'(r.slen);
            type_byte = TYPE_CONNECT;
          end
          KIND_SUBSCRIBE: begin
            rem       = 30'd5 + 30'(r.slen);
            type_byte = TYPE_SUBSCRIBE;
          end
          default: begin
            rem       = 30'd4 + 30'(r.slen) + 30'(r.plen);
            type_byte = TYPE_PUBLISH;
          end
        endcase
        if (rem > REM_LIMIT) begin
          ser_phase = PH_IDLE;
          put_byte(ZERO_BYTE, 1'b1, STATUS_TOO_LONG);
        end else begin
          ser_kind = r.kind;
          str_left = r.slen;
          pay_left = (r.kind == KIND_PUBLISH) ? r.plen : '0;
          id_word  = r.word;
          put_byte(type_byte, 1'b0, STATUS_OK);
          // Remaining length, seven bits per digit, low digit first.
          do begin
            digit = {1'b0, rem[6:0]};
            rem   = rem >> 7;
            if (rem != '0) begin
              digit[7] = 1'b1;
            end
            put_byte(digit, 1'b0, STATUS_OK);
          end while (rem != '0);
          if (r.kind == KIND_CONNECT) begin
            put_byte(ZERO_BYTE, 1'b0, STATUS_OK);
            put_byte(NAME_LEN_LO, 1'b0, STATUS_OK);
            put_byte(8'h4D, 1'b0, STATUS_OK);  // M
            put_byte(8'h51, 1'b0, STATUS_OK);  // Q
            put_byte(8'h54, 1'b0, STATUS_OK);  // T
            put_byte(8'h54, 1'b0, STATUS_OK);  // T
            put_byte(PROTO_LEVEL, 1'b0, STATUS_OK);
            put_byte(CONNECT_FLAGS, 1'b0, STATUS_OK);
          end
          if (r.kind != KIND_PUBLISH) begin
            put_byte(r.word[15:8], 1'b0, STATUS_OK);
            put_byte(r.word[7:0], 1'b0, STATUS_OK);
          end
          put_byte(r.slen[15:8], 1'b0, STATUS_OK);
          put_byte(r.slen[7:0], 1'b0, STATUS_OK);
          if (r.slen == '0) begin
            close_string();
          end else begin
            ser_phase = PH_STRING;
          end
        end
      end
    end else if (ser_phase == PH_STRING) begin
      put_byte(r.data, 1'b0, STATUS_OK);
      str_left = str_left - 1'b1;
      if (str_left == '0) begin
        close_string();
      end
    end else if (ser_phase == PH_PAYLOAD) begin
      pay_left = pay_left - 1'b1;
      put_byte(r.data, pay_left == '0, STATUS_OK);
      if (pay_left == '0) begin
        ser_phase = PH_IDLE;
      end
    end else begin
      put_byte(ZERO_BYTE, 1'b0, STATUS_UNEXPECTED);
    end
    // The last byte of the request carries the run flag.
    w = burst_q.pop_back();
    w.run_last = 1'b1;
    burst_q.push_back(w);
  endfunction

  function automatic request_t row(logic act, logic [KIND_W-1:0] kind, logic [SLEN_W-1:0] slen,
                                   logic [PLEN_W-1:0] plen, logic [WORD_W-1:0] word,
                                   logic [BYTE_W-1:0] data, bit typed, logic t_end,
                                   logic [STATUS_W-1:0] t_status);
    request_t r;
    r.action   = act;
    r.kind     = kind;
    r.slen     = slen;
    r.plen     = plen;
    r.word     = word;
    r.data     = data;
    r.typed    = typed;
    r.t_end    = t_end;
    r.t_status = t_status;
    return r;
  endfunction

  // Hand one request to the block after a random gap and queue what it should produce.
  task automatic drive_request(request_t r);
    int         gap;
    wire_byte_t w;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.action;
    in_tdata  <= {2'b00, r.data, r.word, r.plen, r.slen, r.kind};
    do @(posedge clk); while (!in_tready);
    serialize_request(r);
    if (r.typed) begin
      // Error results carry a zero byte and close the request.
      w.b        = ZERO_BYTE;
      w.run_last = 1'b1;
      w.pend     = r.t_end;
      w.status   = r.t_status;
      wire_byte_q.push_back(w);
    end else begin
      foreach (burst_q[i]) wire_byte_q.push_back(burst_q[i]);
    end
    n_requests++;
    if (r.action == ACT_BEGIN) begin
      n_begins++;
    end
  endtask

  // Switch between quiet stretches with no idling and stretches with random gaps.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc[7:0] == 8'd0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // Receiver: draw a random stall after each accepted byte, none in calm stretches.
  always @(posedge clk) begin : receiver
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        stall = calm ? 0 : $urandom_range(0, 4);
        if (stall != 0) begin
          out_tready <= 1'b0;
          rx_wait    <= stall - 1;
        end
      end
    end else if (rx_wait == 0) begin
      out_tready <= 1'b1;
    end else begin
      rx_wait <= rx_wait - 1;
    end
  end

  // Compare each accepted byte with the oldest expectation.
  always @(posedge clk) begin : result_check
    wire_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tlast) begin
        n_packets++;
      end
      if (out_tuser[2:1] != STATUS_OK) begin
        n_faults++;
      end
      if (wire_byte_q.size() == 0) begin
        report_mismatch("unexpected byte", 0, int'(out_tdata));
      end else begin
        want = wire_byte_q.pop_front();
        if (out_tdata !== want.b) begin
          report_mismatch("out_byte", int'(want.b), int'(out_tdata));
        end
        if (out_tuser[0] !== want.run_last) begin
          report_mismatch("run_last", int'(want.run_last), int'(out_tuser[0]));
        end
        if (out_tlast !== want.pend) begin
          report_mismatch("packet_end", int'(want.pend), int'(out_tlast));
        end
        if (out_tuser[2:1] !== want.status) begin
          report_mismatch("status", int'(want.status), int'(out_tuser[2:1]));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog expired with %0d bytes outstanding.", wire_byte_q.size());
      $display("mqtt_packet_serializer_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    request_t          plan_q[$];
    request_t          r;
    logic [KIND_W-1:0] pkt_kind;
    logic [SLEN_W-1:0] slen;
    logic [PLEN_W-1:0] plen;
    int                pick;
    int                body_n;
    int                stop_at;

    // Directed table: errors and extremes are typed in, the rest goes through the predictor.
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h00, 1, 1'b0, STATUS_UNEXPECTED));
    plan_q.push_back(row(ACT_BEGIN, KIND_UNKNOWN, 16'hFFFF, 28'hFFFFFFF, 16'hFFFF, 8'hFF,
                         1, 1'b1, STATUS_UNEXPECTED));
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 16'hFFFF, 28'hFFFFFFF, 16'hFFFF, 8'h00,
                         1, 1'b1, STATUS_TOO_LONG));
    // Largest legal remaining length: four digits.
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 0, 28'd268435451, 16'hFFFF, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'hFF, 0, 0, 0));
    // One past the largest legal length, abandoning the payload above.
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 1, 28'd268435451, 0, 0,
                         1, 1'b1, STATUS_TOO_LONG));
    // Connect with an empty client id ends on the length prefix.
    plan_q.push_back(row(ACT_BEGIN, KIND_CONNECT, 0, 0, 16'hFFFF, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_CONNECT, 2, 0, 16'h0000, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h00, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'hFF, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_SUBSCRIBE, 0, 0, 16'hA5A5, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_SUBSCRIBE, 1, 0, 16'h1234, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h55, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 1, 0, 16'hBEEF, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h80, 0, 0, 0));
    // Publish with empty topic and payload: prefix and packet id in one request.
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 0, 0, 16'h0001, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 2, 2, 16'h5A5A, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h11, 0, 0, 0));
    // A begin in the middle of the topic drops that packet; two-digit length.
    plan_q.push_back(row(ACT_BEGIN, KIND_CONNECT, 116, 0, 16'h0102, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_PUBLISH, 1, 1, 16'h0000, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h22, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h33, 0, 0, 0));
    plan_q.push_back(row(ACT_BODY, KIND_CONNECT, 0, 0, 0, 8'h00, 1, 1'b0, STATUS_UNEXPECTED));
    // Longest client id: three-digit length, then dropped by an unknown kind.
    plan_q.push_back(row(ACT_BEGIN, KIND_CONNECT, 16'hFFFF, 0, 16'h8001, 0, 0, 0, 0));
    plan_q.push_back(row(ACT_BEGIN, KIND_UNKNOWN, 0, 0, 0, 0, 1, 1'b1, STATUS_UNEXPECTED));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) drive_request(plan_q[i]);

    // Random part: mostly complete packets with random content, the rest noise.
    while (n_requests < plan_q.size() + RANDOM_ITEMS) begin
      pick     = $urandom_range(0, 99);
      pkt_kind = KIND_W'($urandom_range(0, 2));
      slen     = SLEN_W'($urandom);
      plen     = PLEN_W'($urandom);
      body_n   = 0;
      if (pick < 70) begin
        slen = SLEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 8));
        if (pkt_kind == KIND_PUBLISH) begin
          plen = PLEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(120, 300)
                                                     : $urandom_range(0, 10));
        end
        body_n = int'(slen) + ((pkt_kind == KIND_PUBLISH) ? int'(plen) : 0);
        // Now and then cut the packet short; the next begin drops it.
        if (body_n != 0 && $urandom_range(0, 9) == 0) begin
          stop_at = $urandom_range(0, body_n - 1);
          body_n  = stop_at;
        end
      end else if (pick < 80) begin
        // Long lengths for three- and four-digit headers, abandoned after a few bytes.
        if (pkt_kind == KIND_PUBLISH) begin
          slen = SLEN_W'($urandom_range(0, 3));
          plen = PLEN_W'($urandom_range(2097148, 268435451 - slen));
        end
        body_n = $urandom_range(0, 4);
      end else if (pick < 88) begin
        pkt_kind = KIND_W'($urandom);
      end else if (pick < 94) begin
        pkt_kind = KIND_UNKNOWN;
      end else begin
        pkt_kind = KIND_PUBLISH;
        plen     = PLEN_W'($urandom_range(268435452 - slen, 268435455));
      end
      if (pick < 80 || pick >= 88) begin
        r = row(ACT_BEGIN, pkt_kind, slen, plen, WORD_W'($urandom), BYTE_W'($urandom),
                0, 0, 0);
        drive_request(r);
      end else begin
        body_n = 1;
      end
      // Stop the body run once the request budget is spent.
      repeat (body_n) begin
        if (n_requests >= plan_q.size() + RANDOM_ITEMS) break;
        r = row(ACT_BODY, KIND_W'($urandom), SLEN_W'($urandom), PLEN_W'($urandom),
                WORD_W'($urandom), BYTE_W'($urandom), 0, 0, 0);
        drive_request(r);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray bytes.
    while (wire_byte_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (wire_byte_q.size() != 0) begin
      report_mismatch("bytes never produced", wire_byte_q.size(), 0);
    end
    $display("Sent %0d requests (%0d packet begins, %0d body bytes).",
             n_requests, n_begins, n_requests - n_begins);
    $display("Checked %0d output bytes: %0d packet ends, %0d error results, %0d mismatches.",
             n_results, n_packets, n_faults, n_errors);
    if (n_errors == 0) begin
      $display("mqtt_packet_serializer_tb: PASS");
    end else begin
      $display("mqtt_packet_serializer_tb: FAIL");
    end
    $finish;
  end

endmodule
